>>> design/kmw_pkg.sv
// Package for the keyform multilinear weights block.
// Holds the sequencer state type, register and request codes, and fixed widths.
`timescale 1ns / 1ps

package kmw_pkg;

    localparam int FIELD_W    = 16;
    localparam int CFG_DATA_W = 7;
    localparam int CFG_IDX_W  = 3;
    localparam int QUO_W      = 17;
    localparam int PROD_W     = 2 * QUO_W;
    localparam int DIV_CNT_W  = 5;
    localparam int NUM_CH     = 2;
    localparam int OUT_IDX_W  = 6;
    localparam int MIN_KEYS   = 2;
    localparam int MAX_TOTAL  = 64;

    localparam logic [QUO_W-1:0]  ONE_Q16    = 17'h10000;
    localparam logic [PROD_W-1:0] ROUND_HALF = 34'h8000;

    typedef enum logic {
        REQ_LOAD = 1'b0,
        REQ_EVAL = 1'b1
    } t_req;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PARAM_COUNT = 3'd0,
        CFG_KEY_COUNT_A = 3'd1,
        CFG_KEY_COUNT_B = 3'd2,
        CFG_STRIDE_A    = 3'd3,
        CFG_STRIDE_B    = 3'd4,
        CFG_KF_TOTAL    = 3'd5
    } t_cfg_idx;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD_LO,
        S_RD_HI,
        S_CLAMP,
        S_SCAN,
        S_PREP,
        S_DIV,
        S_PFIN,
        S_MUL,
        S_EMIT
    } t_state;

endpackage

>>> design/keyform_multilinear_weights_core.sv
// Top level of the keyform multilinear weights block: key table, search, divider, corners.
// Depends on kmw_pkg and kmw_ram.
`timescale 1ns / 1ps

// Usage:
//   Input channel (i_valid / o_stall) carries load and evaluate transactions.
//   A load writes one key of the per-parameter table and gives no result.
//   An evaluate clamps each parameter value to its key range, searches the segment,
//   divides for a Q0.16 fraction, then emits one result per corner (2 or 4).
//   Output channel (o_valid / i_stall) carries corner results; o_last marks the final one.
//   For each parameter value that falls strictly inside a segment, the shared restoring
//   divider runs, one quotient bit per cycle. Each corner then goes through a multiply
//   and an output load; one item is in flight at a time.
//   o_stall is high while an evaluate is in work. The output register lets a new
//   transaction be accepted while the last corner waits; a stalled receiver holds the
//   sequencer at its next corner. Configuration is written through i_cfg_we and holds
//   the reset values param_count 1, key counts 2, strides 1, keyform total 1.
//   Synchronous active-low reset clears control state and restores the configuration;
//   the key table is undefined until loaded.

module keyform_multilinear_weights_core #(
    parameter int MAX_PARAMS = 2,
    parameter int MAX_KEYS   = 8
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic                                  i_req_type,
    input  logic                                  i_param_sel,
    input  logic [2:0]                            i_key_slot,
    input  logic signed [kmw_pkg::FIELD_W-1:0]    i_key_value,
    input  logic signed [kmw_pkg::FIELD_W-1:0]    i_value_a,
    input  logic signed [kmw_pkg::FIELD_W-1:0]    i_value_b,
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic [1:0]                            o_corner,
    output logic [kmw_pkg::OUT_IDX_W-1:0]         o_keyform_index,
    output logic [kmw_pkg::QUO_W-1:0]             o_weight,
    output logic                                  o_exact_hit,
    output logic [kmw_pkg::OUT_IDX_W-1:0]         o_exact_index,
    output logic                                  o_last,
    input  logic                                  i_cfg_we,
    input  logic [kmw_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [kmw_pkg::CFG_DATA_W-1:0]        i_cfg_data
);

    localparam int DEPTH = MAX_PARAMS * MAX_KEYS;
    localparam int AW    = $clog2(DEPTH);
    localparam int KP_W  = $clog2(MAX_KEYS);
    localparam int CNT_W = $clog2(MAX_KEYS + 1);
    localparam int IW    = CNT_W + 8;
    localparam int EW    = KP_W + 8;
    localparam int LIM   = (MAX_PARAMS < 2) ? MAX_PARAMS : 2;
    localparam int FW    = kmw_pkg::FIELD_W;
    localparam int QW    = kmw_pkg::QUO_W;
    localparam int OW    = kmw_pkg::OUT_IDX_W;

    kmw_pkg::t_state r_state, n_state;

    logic [1:0]                      r_param_count, n_param_count;
    logic [3:0]                      r_key_count_a, n_key_count_a;
    logic [3:0]                      r_key_count_b, n_key_count_b;
    logic [6:0]                      r_stride_a, n_stride_a;
    logic [6:0]                      r_stride_b, n_stride_b;
    logic [6:0]                      r_kf_total, n_kf_total;

    logic                            r_p, n_p;
    logic [KP_W-1:0]                 r_cnt, n_cnt;
    logic [kmw_pkg::DIV_CNT_W-1:0]   r_div_cnt, n_div_cnt;
    logic [1:0]                      r_c, n_c;
    logic                            r_seg_found, n_seg_found;
    logic signed [FW-1:0]            r_val_a, n_val_a;
    logic signed [FW-1:0]            r_val_b, n_val_b;
    logic signed [FW-1:0]            r_klo, n_klo;
    logic signed [FW-1:0]            r_cv, n_cv;
    logic signed [FW-1:0]            r_prev, n_prev;
    logic signed [FW-1:0]            r_lo, n_lo;
    logic signed [FW-1:0]            r_hi, n_hi;
    logic [FW-1:0]                   r_den, n_den;
    logic [FW-1:0]                   r_rem, n_rem;
    logic [QW-1:0]                   r_q, n_q;
    logic [kmw_pkg::PROD_W-1:0]      r_prod, n_prod;
    logic [CNT_W-1:0]                r_seg  [kmw_pkg::NUM_CH];
    logic [CNT_W-1:0]                n_seg  [kmw_pkg::NUM_CH];
    logic [QW-1:0]                   r_frac [kmw_pkg::NUM_CH];
    logic [QW-1:0]                   n_frac [kmw_pkg::NUM_CH];
    logic [KP_W-1:0]                 r_kpos [kmw_pkg::NUM_CH];
    logic [KP_W-1:0]                 n_kpos [kmw_pkg::NUM_CH];
    logic                            r_khit [kmw_pkg::NUM_CH];
    logic                            n_khit [kmw_pkg::NUM_CH];

    logic                            r_ovalid, n_ovalid;
    logic [1:0]                      r_o_corner, n_o_corner;
    logic [OW-1:0]                   r_o_index, n_o_index;
    logic [QW-1:0]                   r_o_weight, n_o_weight;
    logic                            r_o_hit, n_o_hit;
    logic [OW-1:0]                   r_o_exact, n_o_exact;
    logic                            r_o_last, n_o_last;

    logic                            ram_we;
    logic [AW-1:0]                   ram_waddr;
    logic [AW-1:0]                   ram_raddr;
    logic [FW-1:0]                   ram_rdata;

    logic                            in_acc;
    logic                            out_free;
    logic                            load_ok;
    logic [1:0]                      np;
    logic                            np2;
    logic [1:0]                      last_c;
    logic [4:0]                      kca5, kcb5, na5, nb5;
    logic [CNT_W-1:0]                n_cur;
    logic [6:0]                      tot7;
    logic [OW-1:0]                   tot_m1;
    logic [AW-1:0]                   base;
    logic signed [FW-1:0]            v_cur;
    logic signed [FW-1:0]            k_rd;
    logic signed [FW:0]              num;
    logic signed [FW:0]              den;
    logic [QW-1:0]                   div_t;
    logic [QW-1:0]                   div_d;
    logic                            div_ge;
    logic                            p_done;
    logic [QW-1:0]                   fa, fb;
    logic [kmw_pkg::PROD_W-1:0]      wsum;
    logic [QW-1:0]                   weight;
    logic [IW-1:0]                   term_a, term_b, idx_sum;
    logic [OW-1:0]                   idx_cl;
    logic [EW-1:0]                   ex_a, ex_b, ex_sum;
    logic                            hit;
    logic [OW-1:0]                   ex_cl;

    kmw_ram #(
        .WIDTH (FW),
        .DEPTH (DEPTH)
    ) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (i_key_value),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign in_acc   = i_valid && !o_stall;
    assign out_free = !r_ovalid || !i_stall;
    assign o_stall  = (r_state != kmw_pkg::S_IDLE);

    // configuration decode with range saturation
    always_comb begin
        np = r_param_count;
        if (r_param_count == 2'd0) begin
            np = 2'd1;
        end else if (r_param_count > 2'(LIM)) begin
            np = 2'(LIM);
        end
        np2    = (np == 2'd2);
        last_c = np2 ? 2'd3 : 2'd1;

        kca5 = {1'b0, r_key_count_a};
        kcb5 = {1'b0, r_key_count_b};
        na5  = kca5;
        nb5  = kcb5;
        if (kca5 < 5'(kmw_pkg::MIN_KEYS)) begin
            na5 = 5'(kmw_pkg::MIN_KEYS);
        end else if (kca5 > 5'(MAX_KEYS)) begin
            na5 = 5'(MAX_KEYS);
        end
        if (kcb5 < 5'(kmw_pkg::MIN_KEYS)) begin
            nb5 = 5'(kmw_pkg::MIN_KEYS);
        end else if (kcb5 > 5'(MAX_KEYS)) begin
            nb5 = 5'(MAX_KEYS);
        end
        n_cur = r_p ? CNT_W'(nb5) : CNT_W'(na5);

        tot7 = r_kf_total;
        if (r_kf_total == 7'd0) begin
            tot7 = 7'd1;
        end else if (r_kf_total > 7'(kmw_pkg::MAX_TOTAL)) begin
            tot7 = 7'(kmw_pkg::MAX_TOTAL);
        end
        tot_m1 = OW'(tot7 - 7'd1);

        base  = r_p ? AW'(MAX_KEYS) : '0;
        v_cur = r_p ? r_val_b : r_val_a;
        k_rd  = $signed(ram_rdata);

        load_ok = ((i_param_sel == 1'b0) || (MAX_PARAMS > 1))
                  && ({2'b00, i_key_slot} < 5'(MAX_KEYS));
        ram_waddr = i_param_sel ? AW'(MAX_KEYS) + AW'(i_key_slot) : AW'(i_key_slot);
    end

    // segment arithmetic and divider step
    always_comb begin
        num    = $signed({r_cv[FW-1], r_cv}) - $signed({r_lo[FW-1], r_lo});
        den    = $signed({r_hi[FW-1], r_hi}) - $signed({r_lo[FW-1], r_lo});
        div_t  = {r_rem, r_q[QW-1]};
        div_ge = (div_t >= {1'b0, r_den});
        div_d  = div_t - {1'b0, r_den};
    end

    // corner weight and indexes
    always_comb begin
        fa     = r_c[0] ? r_frac[0] : kmw_pkg::ONE_Q16 - r_frac[0];
        fb     = r_c[1] ? r_frac[1] : kmw_pkg::ONE_Q16 - r_frac[1];
        wsum   = r_prod + kmw_pkg::ROUND_HALF;
        weight = np2 ? wsum[32:16] : fa;

        term_a  = (IW'(r_seg[0]) + IW'(r_c[0])) * IW'(r_stride_a);
        term_b  = np2 ? (IW'(r_seg[1]) + IW'(r_c[1])) * IW'(r_stride_b) : '0;
        idx_sum = term_a + term_b;
        idx_cl  = (idx_sum > IW'(tot_m1)) ? tot_m1 : OW'(idx_sum);

        ex_a   = EW'(r_kpos[0]) * EW'(r_stride_a);
        ex_b   = np2 ? EW'(r_kpos[1]) * EW'(r_stride_b) : '0;
        ex_sum = ex_a + ex_b;
        hit    = r_khit[0] && (!np2 || r_khit[1]);
        ex_cl  = '0;
        if (hit) begin
            ex_cl = (ex_sum > EW'(tot_m1)) ? tot_m1 : OW'(ex_sum);
        end
    end

    // sequencer
    always_comb begin
        n_state       = r_state;
        n_param_count = r_param_count;
        n_key_count_a = r_key_count_a;
        n_key_count_b = r_key_count_b;
        n_stride_a    = r_stride_a;
        n_stride_b    = r_stride_b;
        n_kf_total    = r_kf_total;
        n_p           = r_p;
        n_cnt         = r_cnt;
        n_div_cnt     = r_div_cnt;
        n_c           = r_c;
        n_seg_found   = r_seg_found;
        n_val_a       = r_val_a;
        n_val_b       = r_val_b;
        n_klo         = r_klo;
        n_cv          = r_cv;
        n_prev        = r_prev;
        n_lo          = r_lo;
        n_hi          = r_hi;
        n_den         = r_den;
        n_rem         = r_rem;
        n_q           = r_q;
        n_prod        = r_prod;
        n_seg         = r_seg;
        n_frac        = r_frac;
        n_kpos        = r_kpos;
        n_khit        = r_khit;
        n_ovalid      = r_ovalid;
        n_o_corner    = r_o_corner;
        n_o_index     = r_o_index;
        n_o_weight    = r_o_weight;
        n_o_hit       = r_o_hit;
        n_o_exact     = r_o_exact;
        n_o_last      = r_o_last;
        ram_we        = 1'b0;
        ram_raddr     = base;
        p_done        = 1'b0;

        if (i_cfg_we) begin
            case (kmw_pkg::t_cfg_idx'(i_cfg_index))
                kmw_pkg::CFG_PARAM_COUNT: n_param_count = i_cfg_data[1:0];
                kmw_pkg::CFG_KEY_COUNT_A: n_key_count_a = i_cfg_data[3:0];
                kmw_pkg::CFG_KEY_COUNT_B: n_key_count_b = i_cfg_data[3:0];
                kmw_pkg::CFG_STRIDE_A:    n_stride_a    = i_cfg_data;
                kmw_pkg::CFG_STRIDE_B:    n_stride_b    = i_cfg_data;
                kmw_pkg::CFG_KF_TOTAL:    n_kf_total    = i_cfg_data;
                default: ;
            endcase
        end

        if (r_ovalid && !i_stall) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            kmw_pkg::S_IDLE: begin
                if (in_acc) begin
                    if (kmw_pkg::t_req'(i_req_type) == kmw_pkg::REQ_LOAD) begin
                        ram_we = load_ok;
                    end else begin
                        n_val_a = i_value_a;
                        n_val_b = i_value_b;
                        n_p     = 1'b0;
                        n_state = kmw_pkg::S_RD_LO;
                    end
                end
            end
            kmw_pkg::S_RD_LO: begin
                n_state = kmw_pkg::S_RD_HI;
            end
            kmw_pkg::S_RD_HI: begin
                ram_raddr = base + AW'(n_cur - 1'b1);
                n_klo     = k_rd;
                n_state   = kmw_pkg::S_CLAMP;
            end
            kmw_pkg::S_CLAMP: begin
                n_cv = v_cur;
                if (v_cur < r_klo) begin
                    n_cv = r_klo;
                end else if (v_cur > k_rd) begin
                    n_cv = k_rd;
                end
                n_cnt       = '0;
                n_seg_found = 1'b0;
                n_seg[r_p]  = n_cur - 1'b1;
                n_khit[r_p] = 1'b0;
                n_kpos[r_p] = '0;
                n_state     = kmw_pkg::S_SCAN;
            end
            kmw_pkg::S_SCAN: begin
                if ((r_cnt != '0) && !r_seg_found && (r_cv <= k_rd)) begin
                    n_seg_found = 1'b1;
                    n_seg[r_p]  = CNT_W'(r_cnt) - 1'b1;
                    n_lo        = r_prev;
                    n_hi        = k_rd;
                end
                if (!r_khit[r_p] && (k_rd == v_cur)) begin
                    n_khit[r_p] = 1'b1;
                    n_kpos[r_p] = r_cnt;
                end
                n_prev = k_rd;
                if (CNT_W'(r_cnt) == n_cur - 1'b1) begin
                    n_state = kmw_pkg::S_PREP;
                end else begin
                    n_cnt     = r_cnt + 1'b1;
                    ram_raddr = base + AW'(r_cnt) + 1'b1;
                end
            end
            kmw_pkg::S_PREP: begin
                if (r_seg_found && (den > 0) && (num > 0)) begin
                    n_den     = den[FW-1:0];
                    n_rem     = {1'b0, num[FW-1:1]};
                    n_q       = {num[0], 1'b0, den[FW-1:1]};
                    n_div_cnt = kmw_pkg::DIV_CNT_W'(QW - 1);
                    n_state   = kmw_pkg::S_DIV;
                end else begin
                    n_frac[r_p] = '0;
                    p_done      = 1'b1;
                end
            end
            kmw_pkg::S_DIV: begin
                n_rem = div_ge ? div_d[FW-1:0] : div_t[FW-1:0];
                n_q   = {r_q[QW-2:0], div_ge};
                if (r_div_cnt == '0) begin
                    n_state = kmw_pkg::S_PFIN;
                end else begin
                    n_div_cnt = r_div_cnt - 1'b1;
                end
            end
            kmw_pkg::S_PFIN: begin
                if (r_q[QW-1]) begin
                    n_seg[r_p]  = r_seg[r_p] + 1'b1;
                    n_frac[r_p] = '0;
                end else begin
                    n_frac[r_p] = r_q;
                end
                p_done = 1'b1;
            end
            kmw_pkg::S_MUL: begin
                n_prod  = fa * fb;
                n_state = kmw_pkg::S_EMIT;
            end
            kmw_pkg::S_EMIT: begin
                if (out_free) begin
                    n_ovalid   = 1'b1;
                    n_o_corner = r_c;
                    n_o_index  = idx_cl;
                    n_o_weight = weight;
                    n_o_hit    = hit;
                    n_o_exact  = ex_cl;
                    n_o_last   = (r_c == last_c);
                    if (r_c == last_c) begin
                        n_state = kmw_pkg::S_IDLE;
                    end else begin
                        n_c     = r_c + 1'b1;
                        n_state = kmw_pkg::S_MUL;
                    end
                end
            end
            default: begin
                n_state = kmw_pkg::S_IDLE;
            end
        endcase

        if (p_done) begin
            if (!r_p && np2) begin
                n_p     = 1'b1;
                n_state = kmw_pkg::S_RD_LO;
            end else begin
                n_c     = '0;
                n_state = kmw_pkg::S_MUL;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= kmw_pkg::S_IDLE;
            r_param_count <= 2'd1;
            r_key_count_a <= 4'd2;
            r_key_count_b <= 4'd2;
            r_stride_a    <= 7'd1;
            r_stride_b    <= 7'd1;
            r_kf_total    <= 7'd1;
            r_p           <= 1'b0;
            r_cnt         <= '0;
            r_div_cnt     <= '0;
            r_c           <= '0;
            r_seg_found   <= 1'b0;
            r_ovalid      <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_param_count <= n_param_count;
            r_key_count_a <= n_key_count_a;
            r_key_count_b <= n_key_count_b;
            r_stride_a    <= n_stride_a;
            r_stride_b    <= n_stride_b;
            r_kf_total    <= n_kf_total;
            r_p           <= n_p;
            r_cnt         <= n_cnt;
            r_div_cnt     <= n_div_cnt;
            r_c           <= n_c;
            r_seg_found   <= n_seg_found;
            r_ovalid      <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val_a    <= n_val_a;
        r_val_b    <= n_val_b;
        r_klo      <= n_klo;
        r_cv       <= n_cv;
        r_prev     <= n_prev;
        r_lo       <= n_lo;
        r_hi       <= n_hi;
        r_den      <= n_den;
        r_rem      <= n_rem;
        r_q        <= n_q;
        r_prod     <= n_prod;
        r_seg      <= n_seg;
        r_frac     <= n_frac;
        r_kpos     <= n_kpos;
        r_khit     <= n_khit;
        r_o_corner <= n_o_corner;
        r_o_index  <= n_o_index;
        r_o_weight <= n_o_weight;
        r_o_hit    <= n_o_hit;
        r_o_exact  <= n_o_exact;
        r_o_last   <= n_o_last;
    end

    assign o_valid         = r_ovalid;
    assign o_corner        = r_o_corner;
    assign o_keyform_index = r_o_index;
    assign o_weight        = r_o_weight;
    assign o_exact_hit     = r_o_hit;
    assign o_exact_index   = r_o_exact;
    assign o_last          = r_o_last;

endmodule

>>> design/kmw_ram.sv
// Generic single write port, single read port RAM with registered read data.
// Standalone; no package dependency.
`timescale 1ns / 1ps

module kmw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/kmw_checker.sv
// Port-level checks for the keyform multilinear weights block, bound to the top level.
// Depends on kmw_pkg and keyform_multilinear_weights_core.
`timescale 1ns / 1ps

module kmw_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_out_valid,
    input  logic                          i_out_stall,
    input  logic [1:0]                    i_corner,
    input  logic [kmw_pkg::QUO_W-1:0]     i_weight,
    input  logic                          i_exact_hit,
    input  logic [kmw_pkg::OUT_IDX_W-1:0] i_exact_index,
    input  logic                          i_last
);

    a_reset_clears_valid: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_stall |=> i_out_valid && $stable(i_weight) && $stable(i_corner))
        else $error("stalled result changed");

    a_no_hit_zero_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_exact_hit |-> i_exact_index == '0)
        else $error("exact index set without exact hit");

    a_last_corner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_last |-> (i_corner == 2'd1 || i_corner == 2'd3))
        else $error("last flag on a corner that cannot be final");

    a_weight_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_weight <= kmw_pkg::ONE_Q16)
        else $error("corner weight above one");

endmodule

bind keyform_multilinear_weights_core kmw_checker u_kmw_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_valid),
    .i_out_stall   (i_stall),
    .i_corner      (o_corner),
    .i_weight      (o_weight),
    .i_exact_hit   (o_exact_hit),
    .i_exact_index (o_exact_index),
    .i_last        (o_last)
);

>>> sim/testbench.sv
// Self-checking testbench for keyform_multilinear_weights_core: key loads and evaluates.
// A predictor computes all but typed probe results; depends on kmw_pkg and the design files.
`timescale 1ns / 1ps

module testbench;
    import kmw_pkg::*;

    localparam int     KEYS_MAX    = 8;
    localparam longint UNITY       = 65536;
    localparam int     SETTLE      = 80;
    localparam int     STALL_LIMIT = 3000;
    localparam int     PHASES      = 12;
    localparam int     PHASE_ITEMS = 24;
    localparam int     PROBES      = 24;

    typedef enum int {
        SPREAD_WIDE,
        SPREAD_TIGHT,
        SPREAD_SHUFFLED,
        SPREAD_FINE
    } spread_t;

    typedef struct {
        logic [1:0]  corner;
        logic [5:0]  kf_index;
        logic [16:0] weight;
        logic        hit;
        logic [5:0]  exact_idx;
        logic        last;
    } corner_t;

    typedef struct packed {
        t_req        kind;
        logic        sel;
        logic [2:0]  slot;
        logic [15:0] key;
        logic [15:0] val_a;
        logic [15:0] val_b;
        logic        typed;
        logic [16:0] w_lo;
        logic [16:0] w_hi;
        logic        hit;
    } probe_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_valid;
    logic                  o_stall;
    logic                  i_req_type;
    logic                  i_param_sel;
    logic [2:0]            i_key_slot;
    logic signed [15:0]    i_key_value;
    logic signed [15:0]    i_value_a;
    logic signed [15:0]    i_value_b;
    logic                  o_valid;
    logic                  i_stall;
    logic [1:0]            o_corner;
    logic [OUT_IDX_W-1:0]  o_keyform_index;
    logic [QUO_W-1:0]      o_weight;
    logic                  o_exact_hit;
    logic [OUT_IDX_W-1:0]  o_exact_index;
    logic                  o_last;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    logic signed [15:0] key_store [2][KEYS_MAX];
    logic [1:0]         cfg_params;
    logic [3:0]         cfg_keys_a;
    logic [3:0]         cfg_keys_b;
    logic [6:0]         cfg_stride_a;
    logic [6:0]         cfg_stride_b;
    logic [6:0]         cfg_total;

    corner_t pending_corners [$];
    corner_t want;
    int      mismatches = 0;
    int      rx_count = 0;
    int      wait_left = 0;
    int      hold_left = 0;
    bit      rx_idle = 1'b1;
    bit      tx_gaps = 1'b1;
    int      quiet_cycles;

    // Reset config applies here: one parameter, total 1, so every index is zero.
    probe_t probes [PROBES] = '{
        '{REQ_LOAD, 1'b0, 3'd0, 16'hFF00, 16'h0000, 16'h0000, 1'b0, 17'd0, 17'd0, 1'b0},
        '{REQ_LOAD, 1'b0, 3'd1, 16'h0100, 16'h0000, 16'h0000, 1'b0, 17'd0, 17'd0, 1'b0},
        '{REQ_EVAL, 1'b0, 3'd0, 16'h0000, 16'h8000, 16'h7FFF, 1'b1, 17'd65536, 17'd0, 1'b0},
        '{REQ_EVAL, 1'b1, 3'd7, 16'hFFFF, 16'h7FFF, 16'h8000, 1'b1, 17'd65536, 17'd0, 1'b0},
        '{REQ_EVAL, 1'b0, 3'd0, 16'h0000, 16'h0000, 16'hFFFF, 1'b1, 17'd32768, 17'd32768, 1'b0},
        '{REQ_EVAL, 1'b0, 3'd0, 16'h0000, 16'hFF00, 16'h0000, 1'b1, 17'd65536, 17'd0, 1'b1},
        '{REQ_EVAL, 1'b0, 3'd0, 16'h0000, 16'h0100, 16'h0000, 1'b1, 17'd65536, 17'd0, 1'b1},
        '{REQ_EVAL, 1'b0, 3'd0, 16'h0000, 16'h0001, 16'h0000, 1'b0, 17'd0, 17'd0, 1'b0},
        '{REQ_EVAL, 1'b0, 3'd0, 16'h0000, 16'hFFFF, 16'h0000, 1'b0, 17'd0, 17'd0, 1'b0},
        '{REQ_EVAL, 1'b0, 3'd0, 16'h0000, 16'h00FF, 16'h0000, 1'b0, 17'd0, 17'd0, 1'b0},
        // equal adjacent keys
        '{REQ_LOAD, 1'b0, 3'd1, 16'hFF00, 16'h0000, 16'h0000, 1'b0, 17'd0, 17'd0, 1'b0},
        '{REQ_EVAL, 1'b0, 3'd0, 16'h0000, 16'h0064, 16'h0000, 1'b1, 17'd65536, 17'd0, 1'b0},
        '{REQ_EVAL, 1'b0, 3'd0, 16'h0000, 16'hFF00, 16'h0000, 1'b1, 17'd65536, 17'd0, 1'b1},
        // descending keys: no segment, value below segment start
        '{REQ_LOAD, 1'b0, 3'd1, 16'hFE00, 16'h0000, 16'h0000, 1'b0, 17'd0, 17'd0, 1'b0},
        '{REQ_EVAL, 1'b0, 3'd0, 16'h0000, 16'hFED4, 16'h0000, 1'b1, 17'd65536, 17'd0, 1'b0},
        '{REQ_EVAL, 1'b0, 3'd0, 16'h0000, 16'hFE00, 16'h0000, 1'b1, 17'd65536, 17'd0, 1'b1},
        '{REQ_EVAL, 1'b0, 3'd0, 16'h0000, 16'h0000, 16'h0000, 1'b1, 17'd65536, 17'd0, 1'b0},
        // full-range keys
        '{REQ_LOAD, 1'b0, 3'd0, 16'h8000, 16'h0000, 16'h0000, 1'b0, 17'd0, 17'd0, 1'b0},
        '{REQ_LOAD, 1'b0, 3'd1, 16'h7FFF, 16'h0000, 16'h0000, 1'b0, 17'd0, 17'd0, 1'b0},
        '{REQ_EVAL, 1'b0, 3'd0, 16'h0000, 16'h8000, 16'h0000, 1'b1, 17'd65536, 17'd0, 1'b1},
        '{REQ_EVAL, 1'b0, 3'd0, 16'h0000, 16'h7FFF, 16'h0000, 1'b1, 17'd65536, 17'd0, 1'b1},
        '{REQ_EVAL, 1'b0, 3'd0, 16'h0000, 16'h0000, 16'h0000, 1'b0, 17'd0, 17'd0, 1'b0},
        '{REQ_EVAL, 1'b0, 3'd0, 16'h0000, 16'h7FFE, 16'h0000, 1'b0, 17'd0, 17'd0, 1'b0},
        '{REQ_LOAD, 1'b1, 3'd7, 16'h7FFF, 16'hFFFF, 16'hFFFF, 1'b0, 17'd0, 17'd0, 1'b0}
    };

    logic [6:0] presets [6][6] = '{
        '{7'd2, 7'd8,  7'd8, 7'd8,   7'd1,   7'd64},
        '{7'd2, 7'd2,  7'd2, 7'd64,  7'd64,  7'd64},
        '{7'd1, 7'd8,  7'd2, 7'd1,   7'd1,   7'd8},
        '{7'd0, 7'd0,  7'd1, 7'd0,   7'd0,   7'd0},
        '{7'd3, 7'd15, 7'd9, 7'd127, 7'd127, 7'd127},
        '{7'd2, 7'd5,  7'd3, 7'd3,   7'd15,  7'd127}
    };

    keyform_multilinear_weights_core i_dut (.*);

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic int key_span(int p);
        int n;
        n = (p == 0) ? int'(cfg_keys_a) : int'(cfg_keys_b);
        return (n < 2) ? 2 : ((n > KEYS_MAX) ? KEYS_MAX : n);
    endfunction

    function automatic void weigh_corners(logic signed [15:0] val_a, logic signed [15:0] val_b);
        longint  frac [2];
        longint  seg [2];
        longint  step [2];
        longint  v, cv, lo_k, hi_k, num, den, f, w, idx, xidx;
        int      np, tot, n, p, j, c, b;
        bit      hit;
        corner_t r;
        np = (cfg_params == 2'd0) ? 1 : ((cfg_params > 2'd2) ? 2 : int'(cfg_params));
        tot = (cfg_total == 7'd0) ? 1 : ((cfg_total > 7'd64) ? 64 : int'(cfg_total));
        step[0] = cfg_stride_a;
        step[1] = cfg_stride_b;
        xidx = 0;
        hit = 1'b1;
        for (p = 0; p < np; p++) begin
            n = key_span(p);
            v = (p == 0) ? val_a : val_b;
            cv = v;
            lo_k = key_store[p][0];
            hi_k = key_store[p][n-1];
            if (cv < lo_k) begin
                cv = lo_k;
            end else if (cv > hi_k) begin
                cv = hi_k;
            end
            seg[p] = n - 1;
            frac[p] = 0;
            for (j = 0; j + 1 < n; j++) begin
                lo_k = key_store[p][j];
                hi_k = key_store[p][j+1];
                if (cv <= hi_k) begin
                    num = cv - lo_k;
                    den = hi_k - lo_k;
                    seg[p] = j;
                    if (den > 0 && num > 0) begin
                        f = (num * UNITY + den / 2) / den;
                        // rounds to one: advance to the next key
                        if (f >= UNITY) begin
                            seg[p] = j + 1;
                            f = 0;
                        end
                        frac[p] = f;
                    end
                    break;
                end
            end
            for (j = 0; j < n; j++) begin
                lo_k = key_store[p][j];
                if (lo_k == v) break;
            end
            if (j < n) begin
                xidx += step[p] * j;
            end else begin
                hit = 1'b0;
            end
        end
        if (!hit) begin
            xidx = 0;
        end else if (xidx > tot - 1) begin
            xidx = tot - 1;
        end
        for (c = 0; c < (1 << np); c++) begin
            w = UNITY;
            idx = 0;
            for (p = 0; p < np; p++) begin
                b = (c >> p) & 1;
                f = b ? frac[p] : UNITY - frac[p];
                w = (w * f + 32768) >> 16;
                idx += (seg[p] + b) * step[p];
            end
            if (idx > tot - 1) idx = tot - 1;
            r.corner = 2'(c);
            r.kf_index = 6'(idx);
            r.weight = 17'(w);
            r.hit = hit;
            r.exact_idx = 6'(xidx);
            r.last = (c + 1 == (1 << np));
            pending_corners.push_back(r);
        end
    endfunction

    function automatic logic [15:0] pick_value(int p);
        int n, j, k0, k1, v;
        n = key_span(p);
        j = int'($urandom_range(0, n - 1));
        k0 = key_store[p][j];
        k1 = (j + 1 < n) ? int'(key_store[p][j+1]) : k0;
        case ($urandom_range(0, 9))
            0: v = int'($urandom_range(0, 65535)) - 32768;
            1, 2, 3: v = k0;
            4, 5, 6: v = k0 + int'($urandom_range(0, 6)) - 3;
            default: v = (k1 > k0) ? k0 + int'($urandom_range(0, k1 - k0)) : k0;
        endcase
        if (v < -32768) v = -32768;
        if (v > 32767) v = 32767;
        return v[15:0];
    endfunction

    task automatic send_item(t_req kind, logic sel, logic [2:0] slot, logic [15:0] kval,
                             logic [15:0] va, logic [15:0] vb, bit model);
        int gap;
        gap = tx_gaps ? int'($urandom_range(0, 15)) : 0;
        repeat (gap) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_valid <= 1'b1;
        i_req_type <= kind;
        i_param_sel <= sel;
        i_key_slot <= slot;
        i_key_value <= kval;
        i_value_a <= va;
        i_value_b <= vb;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        if (kind == REQ_LOAD) begin
            key_store[sel][slot] = kval;
        end else if (model) begin
            weigh_corners(va, vb);
        end
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [6:0] data);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        case (idx)
            CFG_PARAM_COUNT: cfg_params = data[1:0];
            CFG_KEY_COUNT_A: cfg_keys_a = data[3:0];
            CFG_KEY_COUNT_B: cfg_keys_b = data[3:0];
            CFG_STRIDE_A:    cfg_stride_a = data;
            CFG_STRIDE_B:    cfg_stride_b = data;
            CFG_KF_TOTAL:    cfg_total = data;
            default: ;
        endcase
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_corners.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic note_field(string what, logic [16:0] want_v, logic [16:0] got_v);
        if (want_v !== got_v) begin
            mismatches++;
            if (mismatches <= 100)
                $display("%0t ns: %s expected %0d, got %0d", $time, what, want_v, got_v);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_corners.size() == 0) begin
                mismatches++;
                $display("%0t ns: result with none expected, expected nothing, got corner %0d weight %0d",
                         $time, o_corner, o_weight);
            end else begin
                want = pending_corners.pop_front();
                note_field("corner", 17'(want.corner), 17'(o_corner));
                note_field("keyform_index", 17'(want.kf_index), 17'(o_keyform_index));
                note_field("weight", want.weight, o_weight);
                note_field("exact_hit", 17'(want.hit), 17'(o_exact_hit));
                note_field("exact_index", 17'(want.exact_idx), 17'(o_exact_index));
                note_field("last", 17'(want.last), 17'(o_last));
            end
            rx_count++;
            wait_left = rx_idle ? int'($urandom_range(0, 15)) : 0;
            if (rx_count % 64 == 0) rx_idle = ($urandom_range(0, 2) != 0);
            // hold off long enough to back up the input
            if (rx_count == 150 || rx_count == 450) hold_left = 400;
        end
    end

    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else if (wait_left > 0) begin
            wait_left--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    initial begin
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall) || i_cfg_we)
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("FAILURE");
        $finish;
    end

    initial begin
        probe_t     row;
        corner_t    typed_c;
        logic [6:0] regs [6];
        spread_t    spread;
        int         r, c, ph, i, p, s, k;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_stall = 1'b0;
        i_req_type = REQ_LOAD;
        i_param_sel = 1'b0;
        i_key_slot = '0;
        i_key_value = '0;
        i_value_a = '0;
        i_value_b = '0;
        i_cfg_we = 1'b0;
        i_cfg_index = CFG_PARAM_COUNT;
        i_cfg_data = '0;
        for (p = 0; p < 2; p++)
            for (s = 0; s < KEYS_MAX; s++)
                key_store[p][s] = '0;
        cfg_params = 2'd1;
        cfg_keys_a = 4'd2;
        cfg_keys_b = 4'd2;
        cfg_stride_a = 7'd1;
        cfg_stride_b = 7'd1;
        cfg_total = 7'd1;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (r = 0; r < PROBES; r++) begin
            row = probes[r];
            send_item(row.kind, row.sel, row.slot, row.key, row.val_a, row.val_b, !row.typed);
            if (row.typed) begin
                for (c = 0; c < 2; c++) begin
                    typed_c.corner = 2'(c);
                    typed_c.kf_index = '0;
                    typed_c.weight = (c == 0) ? row.w_lo : row.w_hi;
                    typed_c.hit = row.hit;
                    typed_c.exact_idx = '0;
                    typed_c.last = (c == 1);
                    pending_corners.push_back(typed_c);
                end
            end
        end

        for (ph = 0; ph < PHASES; ph++) begin
            drain();
            if (ph < 6) begin
                regs = presets[ph];
            end else begin
                regs[0] = 7'($urandom_range(0, 3));
                regs[1] = 7'($urandom_range(0, 15));
                regs[2] = 7'($urandom_range(0, 15));
                regs[3] = 7'($urandom_range(0, 127));
                regs[4] = 7'($urandom_range(0, 127));
                regs[5] = 7'($urandom_range(0, 127));
            end
            write_reg(CFG_PARAM_COUNT, regs[0]);
            write_reg(CFG_KEY_COUNT_A, regs[1]);
            write_reg(CFG_KEY_COUNT_B, regs[2]);
            write_reg(CFG_STRIDE_A, regs[3]);
            write_reg(CFG_STRIDE_B, regs[4]);
            write_reg(CFG_KF_TOTAL, regs[5]);
            @(negedge i_clk);
            i_cfg_we <= 1'b0;

            tx_gaps = ($urandom_range(0, 3) != 0);
            spread = (ph < 4) ? spread_t'(ph) : spread_t'($urandom_range(0, 3));
            for (p = 0; p < 2; p++) begin
                case (spread)
                    SPREAD_WIDE:  k = -32768 + int'($urandom_range(0, 8191));
                    SPREAD_TIGHT: k = int'($urandom_range(0, 4000)) - 2000;
                    default:      k = int'($urandom_range(0, 200)) - 100;
                endcase
                for (s = 0; s < KEYS_MAX; s++) begin
                    if (spread == SPREAD_SHUFFLED) k = int'($urandom_range(0, 65535)) - 32768;
                    send_item(REQ_LOAD, p[0], s[2:0], k[15:0], 16'($urandom), 16'($urandom),
                              1'b1);
                    case (spread)
                        SPREAD_WIDE:  k += int'($urandom_range(0, 8191));
                        SPREAD_TIGHT: k += ($urandom_range(0, 3) == 0) ? 0
                                           : int'($urandom_range(1, 600));
                        default:      k += int'($urandom_range(1, 3));
                    endcase
                end
            end

            for (i = 0; i < PHASE_ITEMS; i++) begin
                if ($urandom_range(0, 4) == 0)
                    send_item(REQ_LOAD, 1'($urandom), 3'($urandom), 16'($urandom),
                              16'($urandom), 16'($urandom), 1'b1);
                else
                    send_item(REQ_EVAL, 1'($urandom), 3'($urandom), 16'($urandom),
                              pick_value(0), pick_value(1), 1'b1);
            end
        end

        drain();
        if (mismatches == 0 && pending_corners.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
